// ----- design/smtvm_pkg.sv -----
// ============================================================================
// smtvm_pkg : shared types and constants
// Widths, command codes, sequencer states and datapath control for the
// scaled transposed matrix-vector multiply-accumulate block.
// ============================================================================
package smtvm_pkg;

    // default sizing handed to the top-level parameters
    localparam int MAX_ROWS_DEF = 256;
    localparam int MAX_COLS_DEF = 16;

    // fixed field widths
    localparam int CMD_W  = 2;
    localparam int ROW_W  = 8;
    localparam int COL_W  = 4;
    localparam int DATA_W = 16;
    localparam int NCOL_W = 5;
    localparam int OUT_W  = 32;

    // arithmetic widths: alpha*x is Q16.16, times w gives Q.24 in 48 bits
    localparam int AX_W   = 32;
    localparam int PROD_W = 48;
    localparam int ACC_W  = 56;

    // wide enough for column counts up to the largest MAX_COLS (64)
    localparam int CNT_W  = 7;
    // wide enough for row counts up to the largest MAX_ROWS (4096)
    localparam int RCNT_W = 13;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WEIGHT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INIT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FEATURE = 2'd2;

    // configuration register indexes
    localparam logic CFG_ALPHA    = 1'b0;
    localparam logic CFG_NUM_COLS = 1'b1;

    localparam logic [DATA_W-1:0] ALPHA_RST    = 16'd256;
    localparam logic [NCOL_W-1:0] NUM_COLS_RST = 5'd16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AX,
        S_MAC,
        S_DRAIN,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    // control from the sequencer to the shared multiply-accumulate unit
    typedef struct packed {
        logic ld_ax;   // form alpha * x
        logic mul_en;  // form ax * w for the column read last cycle
    } t_mac_ctrl;

endpackage

// ----- design/smtvm_wmem.sv -----
// ============================================================================
// smtvm_wmem : weight store
// Single write port, single read port with registered read data. No reset;
// entries are undefined until written.
// ============================================================================
module smtvm_wmem #(
    parameter int MAX_ROWS = smtvm_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = smtvm_pkg::MAX_COLS_DEF,
    parameter int RB       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    parameter int CB       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [RB-1:0]                     i_wr_row,
    input  logic [CB-1:0]                     i_wr_col,
    input  logic [smtvm_pkg::DATA_W-1:0]      i_wdata,
    input  logic [RB-1:0]                     i_rd_row,
    input  logic [CB-1:0]                     i_rd_col,
    output logic [smtvm_pkg::DATA_W-1:0]      o_rdata
);

    localparam int DEPTH = MAX_ROWS * (2 ** CB);

    logic [smtvm_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [smtvm_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[{i_wr_row, i_wr_col}] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[{i_rd_row, i_rd_col}];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/smtvm_accmem.sv -----
// ============================================================================
// smtvm_accmem : accumulator store
// One write and one registered read port. Per-entry valid bits cleared by
// reset make an unwritten accumulator read as zero.
// ============================================================================
module smtvm_accmem #(
    parameter int MAX_COLS = smtvm_pkg::MAX_COLS_DEF,
    parameter int CB       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [CB-1:0]                 i_waddr,
    input  logic [smtvm_pkg::ACC_W-1:0]   i_wdata,
    input  logic [CB-1:0]                 i_raddr,
    output logic [smtvm_pkg::ACC_W-1:0]   o_rdata
);

    logic [smtvm_pkg::ACC_W-1:0] r_mem [MAX_COLS];
    logic [MAX_COLS-1:0]         r_vld;
    logic [smtvm_pkg::ACC_W-1:0] r_rdata;
    logic                        r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

// ----- design/smtvm_mac.sv -----
// ============================================================================
// smtvm_mac : shared multiply-accumulate unit
// One 32x16 signed multiplier, used first for alpha*x and then once per
// column for ax*w, followed by a 56-bit add of the registered product and accumulator.
// ============================================================================
module smtvm_mac (
    input  logic                                 i_clk,
    input  smtvm_pkg::t_mac_ctrl                 i_ctrl,
    input  logic signed [smtvm_pkg::DATA_W-1:0]  i_alpha,
    input  logic signed [smtvm_pkg::DATA_W-1:0]  i_feat,
    input  logic signed [smtvm_pkg::DATA_W-1:0]  i_weight,
    input  logic [smtvm_pkg::ACC_W-1:0]          i_acc,
    output logic [smtvm_pkg::ACC_W-1:0]          o_sum
);

    logic signed [smtvm_pkg::AX_W-1:0]   mul_a;
    logic signed [smtvm_pkg::DATA_W-1:0] mul_b;
    logic signed [smtvm_pkg::PROD_W-1:0] mul_p;

    logic signed [smtvm_pkg::AX_W-1:0]   r_ax;
    logic signed [smtvm_pkg::PROD_W-1:0] r_prod;
    logic [smtvm_pkg::ACC_W-1:0]         r_acc_q;

    always_comb begin
        if (i_ctrl.ld_ax) begin
            mul_a = smtvm_pkg::AX_W'(i_feat);
            mul_b = i_alpha;
        end else begin
            mul_a = r_ax;
            mul_b = i_weight;
        end
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_ax) begin
            // |alpha*x| <= 2^30, so the low 32 bits hold it exactly
            r_ax <= mul_p[smtvm_pkg::AX_W-1:0];
        end
        if (i_ctrl.mul_en) begin
            r_prod  <= mul_p;
            r_acc_q <= i_acc;
        end
    end

    // product sign-extended to accumulator width, wraps modulo 2^56
    assign o_sum = r_acc_q + smtvm_pkg::ACC_W'(r_prod);

endmodule

// ----- design/scaled_matrix_transpose_vector_mac.sv -----
// ============================================================================
// scaled_matrix_transpose_vector_mac : y += alpha * W^T * x, fixed point
// Sequencer, output register and configuration registers around a shared
// multiply-accumulate unit, a weight store and an accumulator store.
// ============================================================================
// Use:
//  - Slave stream carries commands: weight write, accumulator init and
//    feature element. tlast on a feature element requests emission.
//  - Master stream returns one transaction per active column, column order,
//    tlast on the final one.
//  - Config port (alpha, num_cols): write only while idle; block does not enforce.
// Timing:
//  - Weight and init transactions are written on acceptance.
//  - A feature element with an in-range row passes through acceptance, then
//    alpha*x, then one column per cycle through the single multiplier for
//    n = min(num_cols, MAX_COLS) columns, then a drain of the multiply and
//    add stages.
//  - Emission then reads each result from the accumulator store and loads
//    it into the output register, waiting while the receiver stalls.
//  - tready is low for the whole of that work.
// Reset: accumulators read as zero, alpha = 1.0, num_cols = 16; the weight
//  store is not cleared. Stalls: the output register holds its transaction
//  until taken; the last result may wait there while new input is accepted.
// ============================================================================
module scaled_matrix_transpose_vector_mac #(
    parameter int MAX_ROWS = smtvm_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = smtvm_pkg::MAX_COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // cmd[1:0], row[9:2], col[13:10], value[29:14]
    input  logic        i_s_tlast,   // last
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // out_index[3:0], out_value[35:4]
    output logic        o_m_tlast,   // out_last
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    localparam int RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CB = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    localparam int DW = smtvm_pkg::DATA_W;
    localparam int AW = smtvm_pkg::ACC_W;
    localparam int NW = smtvm_pkg::CNT_W;

    // ---- input field split ----
    logic [smtvm_pkg::CMD_W-1:0] in_cmd;
    logic [smtvm_pkg::ROW_W-1:0] in_row;
    logic [smtvm_pkg::COL_W-1:0] in_col;
    logic [DW-1:0]               in_val;
    logic                        in_acc;
    logic                        in_row_ok;
    logic                        in_col_ok;

    assign in_cmd = i_s_tdata[1:0];
    assign in_row = i_s_tdata[9:2];
    assign in_col = i_s_tdata[13:10];
    assign in_val = i_s_tdata[29:14];

    assign in_acc    = i_s_tvalid && o_s_tready;
    assign in_row_ok = smtvm_pkg::RCNT_W'(in_row) < smtvm_pkg::RCNT_W'(MAX_ROWS);
    assign in_col_ok = NW'(in_col) < NW'(MAX_COLS);

    // ---- configuration registers ----
    logic [DW-1:0]                r_alpha;
    logic [smtvm_pkg::NCOL_W-1:0] r_num_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= smtvm_pkg::ALPHA_RST;
            r_num_cols <= smtvm_pkg::NUM_COLS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                smtvm_pkg::CFG_ALPHA:    r_alpha    <= i_cfg_wdata;
                smtvm_pkg::CFG_NUM_COLS: r_num_cols <= i_cfg_wdata[smtvm_pkg::NCOL_W-1:0];
                default: ;
            endcase
        end
    end

    // active column count, clipped to the store
    logic [NW-1:0] n_act;
    assign n_act = (NW'(r_num_cols) < NW'(MAX_COLS)) ? NW'(r_num_cols) : NW'(MAX_COLS);

    // ---- sequencer state ----
    smtvm_pkg::t_state r_state, n_state;
    logic [CB-1:0]     r_j, n_j;
    logic [RB-1:0]     r_row;
    logic              r_row_ok;
    logic [DW-1:0]     r_val;
    logic              r_last;

    // multiply and add stage tags
    logic              r_s1_vld, r_s2_vld;
    logic [CB-1:0]     r_s1_j, r_s2_j;

    // output register
    logic              r_out_vld;
    logic [CB-1:0]     r_out_idx;
    logic [31:0]       r_out_val;
    logic              r_out_last;

    logic              j_last;
    logic              slot_free;
    logic              out_load;
    logic              feat_acc;
    smtvm_pkg::t_mac_ctrl mac_ctrl;

    assign j_last    = (NW'(r_j) + NW'(1)) == n_act;
    assign slot_free = !r_out_vld || i_m_tready;
    assign feat_acc  = in_acc && (in_cmd == smtvm_pkg::CMD_FEATURE);

    assign o_s_tready = (r_state == smtvm_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= smtvm_pkg::S_IDLE;
            r_j      <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_j      <= n_j;
            r_s1_vld <= (r_state == smtvm_pkg::S_MAC);
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_j <= r_j;
        r_s2_j <= r_s1_j;
        if (feat_acc) begin
            r_row    <= RB'(in_row);
            r_row_ok <= in_row_ok;
            r_val    <= in_val;
            r_last   <= i_s_tlast;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_j             = r_j;
        mac_ctrl.ld_ax  = 1'b0;
        mac_ctrl.mul_en = r_s1_vld;
        out_load        = 1'b0;
        unique case (r_state)
            smtvm_pkg::S_IDLE: begin
                if (feat_acc) begin
                    n_state = smtvm_pkg::S_AX;
                end
            end
            smtvm_pkg::S_AX: begin
                mac_ctrl.ld_ax = 1'b1;
                n_j            = '0;
                if (n_act == '0) begin
                    n_state = smtvm_pkg::S_IDLE;
                end else if (r_row_ok) begin
                    n_state = smtvm_pkg::S_MAC;
                end else if (r_last) begin
                    n_state = smtvm_pkg::S_EMIT_RD;
                end else begin
                    n_state = smtvm_pkg::S_IDLE;
                end
            end
            smtvm_pkg::S_MAC: begin
                // one column issued per cycle
                if (j_last) begin
                    n_state = smtvm_pkg::S_DRAIN;
                end else begin
                    n_j = r_j + CB'(1);
                end
            end
            smtvm_pkg::S_DRAIN: begin
                if (!r_s1_vld && !r_s2_vld) begin
                    n_j     = '0;
                    n_state = r_last ? smtvm_pkg::S_EMIT_RD : smtvm_pkg::S_IDLE;
                end
            end
            smtvm_pkg::S_EMIT_RD: begin
                n_state = smtvm_pkg::S_EMIT_LD;
            end
            smtvm_pkg::S_EMIT_LD: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    if (j_last) begin
                        n_state = smtvm_pkg::S_IDLE;
                    end else begin
                        n_j     = r_j + CB'(1);
                        n_state = smtvm_pkg::S_EMIT_RD;
                    end
                end
            end
            default: n_state = smtvm_pkg::S_IDLE;
        endcase
    end

    // ---- stores and shared unit ----
    logic [DW-1:0] w_rdata;
    logic [AW-1:0] acc_rdata;
    logic [AW-1:0] mac_sum;
    logic          acc_we;
    logic [CB-1:0] acc_waddr;
    logic [AW-1:0] acc_wdata;
    logic          init_we;
    logic          wgt_we;

    assign wgt_we  = in_acc && (in_cmd == smtvm_pkg::CMD_WEIGHT) && in_row_ok && in_col_ok;
    assign init_we = in_acc && (in_cmd == smtvm_pkg::CMD_INIT) && in_col_ok;

    // init places Q8.8 into Q.24; MAC write-back never overlaps an init
    assign acc_we    = init_we || r_s2_vld;
    assign acc_waddr = r_s2_vld ? r_s2_j : CB'(in_col);
    assign acc_wdata = r_s2_vld ? mac_sum : {{(AW-DW-16){in_val[DW-1]}}, in_val, 16'b0};

    smtvm_wmem #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .RB       (RB),
        .CB       (CB)
    ) u_wmem (
        .i_clk    (i_clk),
        .i_we     (wgt_we),
        .i_wr_row (RB'(in_row)),
        .i_wr_col (CB'(in_col)),
        .i_wdata  (in_val),
        .i_rd_row (r_row),
        .i_rd_col (r_j),
        .o_rdata  (w_rdata)
    );

    smtvm_accmem #(
        .MAX_COLS (MAX_COLS),
        .CB       (CB)
    ) u_accmem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (acc_we),
        .i_waddr  (acc_waddr),
        .i_wdata  (acc_wdata),
        .i_raddr  (r_j),
        .o_rdata  (acc_rdata)
    );

    smtvm_mac u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (mac_ctrl),
        .i_alpha  (r_alpha),
        .i_feat   (r_val),
        .i_weight (w_rdata),
        .i_acc    (acc_rdata),
        .o_sum    (mac_sum)
    );

    // ---- emission: floor shift by 16, saturate to 32 bits ----
    logic [31:0] emit_val;
    logic        emit_fits;

    // acc >>> 16 fits 32 bits when bits 55..47 all agree
    assign emit_fits = (acc_rdata[AW-1:47] == '0) || (acc_rdata[AW-1:47] == '1);
    assign emit_val  = emit_fits ? acc_rdata[47:16]
                     : (acc_rdata[AW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_idx  <= r_j;
            r_out_val  <= emit_val;
            r_out_last <= j_last;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {4'b0, r_out_val, smtvm_pkg::COL_W'(r_out_idx)};
    assign o_m_tlast  = r_out_last;

    // ---- checks ----
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld || r_s2_vld) |-> !o_s_tready)
        else $error("input accepted while MAC stages busy");

    a_mac_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == smtvm_pkg::S_MAC) |-> (NW'(r_j) < n_act))
        else $error("MAC column beyond active count");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_m_tvalid && (o_m_tlast == $past(j_last))))
        else $error("emitted result not presented");

    a_rst_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_m_tvalid && !r_s1_vld))
        else $error("activity straight after reset");

endmodule
